[hdl/stable_priority_queue_assert.svh]
// Assertion macros shared by the stable priority queue design.
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stable_priority_queue assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stable_priority_queue assertion failed");

`endif

[hdl/spq_pkg.sv]
// Package with the constants, codes and types of the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int ID_BITS       = 8;
    localparam int PRIORITY_BITS = 8;
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_SERVE  = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REMOVE,
        S_INSERT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load_req;
        logic do_remove;
        logic do_insert;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       out_free;
    } dp_status_t;

endpackage

[hdl/spq_datapath.sv]
// Datapath of the stable priority queue: sorted entry array, request and result registers.
`timescale 1ns / 1ps

module spq_datapath import spq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctrl_cmd_t                cmd,
    input  logic [1:0]               opcode,
    input  logic [ID_BITS-1:0]       requester_id,
    input  logic [PRIORITY_BITS-1:0] priority_req,
    input  logic                     out_ready,
    output dp_status_t               sts,
    output logic                     out_valid,
    output logic [1:0]               status,
    output logic [ID_BITS-1:0]       served_id,
    output logic [CNT_W-1:0]         occupancy
);

    logic [ID_BITS-1:0]       ids_reg   [QUEUE_DEPTH];
    logic [ID_BITS-1:0]       ids_next  [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] pris_reg  [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] pris_next [QUEUE_DEPTH];
    logic [ID_BITS-1:0]       ids_up    [QUEUE_DEPTH];
    logic [ID_BITS-1:0]       ids_dn    [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] pris_up   [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] pris_dn   [QUEUE_DEPTH];

    logic [CNT_W-1:0]         count_reg, count_next;
    logic [1:0]               op_reg, op_next;
    logic [ID_BITS-1:0]       id_reg, id_next;
    logic [PRIORITY_BITS-1:0] pri_reg, pri_next;
    logic [1:0]               res_status_reg, res_status_next;
    logic [ID_BITS-1:0]       served_reg, served_next;

    logic                     out_valid_reg, out_valid_next;
    logic [1:0]               status_out_reg, status_out_next;
    logic [ID_BITS-1:0]       served_out_reg, served_out_next;
    logic [CNT_W-1:0]         occ_out_reg, occ_out_next;

    logic [QUEUE_DEPTH-1:0]   valid;
    logic [QUEUE_DEPTH-1:0]   match;
    logic [QUEUE_DEPTH-1:0]   found_upto;
    logic [QUEUE_DEPTH-1:0]   lower;
    logic [QUEUE_DEPTH-1:0]   ins_here;
    logic                     any_match;
    logic                     is_full;

    // Per-entry flags and the neighbor taps used by the shift in either direction.
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : gen_entry
            assign valid[g]      = count_reg > CNT_W'(g);
            assign match[g]      = (op_reg == OP_SERVE) ? ((g == 0) && valid[g])
                                                        : (valid[g] && ids_reg[g] == id_reg);
            assign found_upto[g] = |match[g:0];
            assign lower[g]      = valid[g] && (pris_reg[g] <= pri_reg);
            if (g == 0) begin : gen_first
                assign ins_here[g] = !lower[g];
                assign ids_dn[g]   = id_reg;
                assign pris_dn[g]  = pri_reg;
            end
            else begin : gen_rest
                assign ins_here[g] = !lower[g] && lower[g-1];
                assign ids_dn[g]   = ids_reg[g-1];
                assign pris_dn[g]  = pris_reg[g-1];
            end
            if (g == QUEUE_DEPTH - 1) begin : gen_last
                assign ids_up[g]  = ids_reg[g];
                assign pris_up[g] = pris_reg[g];
            end
            else begin : gen_inner
                assign ids_up[g]  = ids_reg[g+1];
                assign pris_up[g] = pris_reg[g+1];
            end
        end
    endgenerate

    assign any_match = |match;
    assign is_full   = count_reg == CNT_W'(QUEUE_DEPTH);

    always_comb
    begin
        ids_next        = ids_reg;
        pris_next       = pris_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        pri_next        = pri_reg;
        res_status_next = res_status_reg;
        served_next     = served_reg;

        if (cmd.load_req)
        begin
            op_next         = opcode;
            id_next         = requester_id;
            pri_next        = priority_req;
            res_status_next = ST_DONE;
            served_next     = '0;
        end

        if (cmd.do_remove)
        begin
            if (any_match)
            begin
                for (int i = 0; i < QUEUE_DEPTH; i++)
                begin
                    if (found_upto[i])
                    begin
                        ids_next[i]  = ids_up[i];
                        pris_next[i] = pris_up[i];
                    end
                end
                count_next = count_reg - CNT_W'(1);
                if (op_reg == OP_SERVE)
                begin
                    served_next = ids_reg[0];
                end
            end
            else if (op_reg == OP_SERVE)
            begin
                res_status_next = ST_EMPTY;
            end
            else if (op_reg == OP_REMOVE)
            begin
                res_status_next = ST_NOT_FOUND;
            end
        end

        if (cmd.do_insert)
        begin
            if (is_full)
            begin
                res_status_next = ST_FULL;
            end
            else
            begin
                for (int i = 0; i < QUEUE_DEPTH; i++)
                begin
                    if (ins_here[i])
                    begin
                        ids_next[i]  = id_reg;
                        pris_next[i] = pri_reg;
                    end
                    else if (!lower[i])
                    begin
                        ids_next[i]  = ids_dn[i];
                        pris_next[i] = pris_dn[i];
                    end
                end
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        status_out_next = status_out_reg;
        served_out_next = served_out_reg;
        occ_out_next    = occ_out_reg;
        if (cmd.load_out)
        begin
            out_valid_next  = 1'b1;
            status_out_next = res_status_reg;
            served_out_next = served_reg;
            occ_out_next    = count_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ids_reg         <= ids_next;
        pris_reg        <= pris_next;
        op_reg          <= op_next;
        id_reg          <= id_next;
        pri_reg         <= pri_next;
        res_status_reg  <= res_status_next;
        served_reg      <= served_next;
        status_out_reg  <= status_out_next;
        served_out_reg  <= served_out_next;
        occ_out_reg     <= occ_out_next;
    end

    assign sts.op       = op_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign status    = status_out_reg;
    assign served_id = served_out_reg;
    assign occupancy = occ_out_reg;

endmodule

[hdl/spq_controller.sv]
// Controller state machine that sequences the remove and insert steps of each transaction.
`timescale 1ns / 1ps

module spq_controller import spq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] opcode,
    input  dp_status_t sts,
    output logic       in_ready,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (opcode == OP_INSERT) ? S_INSERT : S_REMOVE;
                end
            end
            S_REMOVE:
            begin
                state_next = (sts.op == OP_UPDATE) ? S_INSERT : S_FINISH;
            end
            S_INSERT:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_req = in_valid;
            end
            S_REMOVE:
            begin
                cmd.do_remove = 1'b1;
            end
            S_INSERT:
            begin
                cmd.do_insert = 1'b1;
            end
            S_FINISH:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/stable_priority_queue.sv]
// Each accepted transaction runs S_REMOVE (remove, serve), S_INSERT (insert) or both (update),
// then waits in S_FINISH until the output register is free and its result is registered there;
// a new transaction is taken only in S_IDLE, once the last one has left S_FINISH.
// A finished result waits in the output register while the next transaction is taken.
// Reset is asynchronous and active low; it empties the queue at once, with no clearing pass.
`timescale 1ns / 1ps
`include "stable_priority_queue_assert.svh"

module stable_priority_queue import spq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               opcode,
    input  logic [ID_BITS-1:0]       requester_id,
    input  logic [PRIORITY_BITS-1:0] priority_req,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic [ID_BITS-1:0]       served_id,
    output logic [CNT_W-1:0]         occupancy
);

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    spq_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    spq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .opcode       (opcode),
        .requester_id (requester_id),
        .priority_req (priority_req),
        .out_ready    (out_ready),
        .sts          (sts),
        .out_valid    (out_valid),
        .status       (status),
        .served_id    (served_id),
        .occupancy    (occupancy)
    );

    `SPQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `SPQ_ASSERT_SAME(a_occ_bound, clk, rst_n, out_valid, occupancy <= CNT_W'(QUEUE_DEPTH))
    `SPQ_ASSERT_SAME(a_empty_result, clk, rst_n, out_valid && status == ST_EMPTY, served_id == '0 && occupancy == '0)
    `SPQ_ASSERT_SAME(a_full_result, clk, rst_n, out_valid && status == ST_FULL, occupancy == CNT_W'(QUEUE_DEPTH))

endmodule

[sim/tb_stable_priority_queue.sv]
// Self-checking testbench for the stable priority queue: directed and random requests.
`timescale 1ns / 1ps

module tb_stable_priority_queue;
    import spq_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 367;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [1:0]         status;
        logic [ID_BITS-1:0] served;
        logic [CNT_W-1:0]   occupancy;
    } response_t;

    // Sorted-list model of the queue; each accepted transaction adds one expected response.
    class queue_scoreboard;
        logic [ID_BITS-1:0]       entry_ids [QUEUE_DEPTH];
        logic [PRIORITY_BITS-1:0] entry_pris [QUEUE_DEPTH];
        int                       entry_count;
        response_t                expected_responses [$];
        int                       mismatches;

        function new();
            entry_count = 0;
            mismatches  = 0;
        endfunction

        function bit place_entry(logic [ID_BITS-1:0] id, logic [PRIORITY_BITS-1:0] pri);
            int pos;
            int i;
            pos = 0;
            if (entry_count >= QUEUE_DEPTH)
            begin
                return 1'b0;
            end
            while (pos < entry_count && entry_pris[pos] <= pri)
            begin
                pos++;
            end
            for (i = entry_count; i > pos; i--)
            begin
                entry_ids[i]  = entry_ids[i - 1];
                entry_pris[i] = entry_pris[i - 1];
            end
            entry_ids[pos]  = id;
            entry_pris[pos] = pri;
            entry_count++;
            return 1'b1;
        endfunction

        function void drop_entry(int pos);
            int i;
            for (i = pos; i + 1 < entry_count; i++)
            begin
                entry_ids[i]  = entry_ids[i + 1];
                entry_pris[i] = entry_pris[i + 1];
            end
            entry_count--;
        endfunction

        function bit take_entry(logic [ID_BITS-1:0] id);
            int i;
            for (i = 0; i < entry_count; i++)
            begin
                if (entry_ids[i] == id)
                begin
                    drop_entry(i);
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void predict_request(logic [1:0] op, logic [ID_BITS-1:0] id,
                                      logic [PRIORITY_BITS-1:0] pri);
            response_t want;
            want.status = ST_DONE;
            want.served = '0;
            case (op)
                OP_INSERT:
                begin
                    if (!place_entry(id, pri))
                    begin
                        want.status = ST_FULL;
                    end
                end
                OP_REMOVE:
                begin
                    if (!take_entry(id))
                    begin
                        want.status = ST_NOT_FOUND;
                    end
                end
                OP_UPDATE:
                begin
                    void'(take_entry(id));
                    if (!place_entry(id, pri))
                    begin
                        want.status = ST_FULL;
                    end
                end
                default:
                begin
                    if (entry_count == 0)
                    begin
                        want.status = ST_EMPTY;
                    end
                    else
                    begin
                        want.served = entry_ids[0];
                        drop_entry(0);
                    end
                end
            endcase
            want.occupancy = CNT_W'(entry_count);
            expected_responses.push_back(want);
        endfunction

        function void check_response(logic [1:0] status, logic [ID_BITS-1:0] served,
                                     logic [CNT_W-1:0] occupancy);
            response_t want;
            if (expected_responses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("Unexpected response: status %0d served %0d occupancy %0d",
                             status, served, occupancy);
                end
                return;
            end
            want = expected_responses.pop_front();
            if (status !== want.status || served !== want.served ||
                occupancy !== want.occupancy)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("Mismatch at %0t: expected status %0d served %0d occupancy %0d,",
                             $realtime, want.status, want.served, want.occupancy);
                    $display("    got status %0d served %0d occupancy %0d",
                             status, served, occupancy);
                end
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               opcode = OP_INSERT;
    logic [ID_BITS-1:0]       requester_id = '0;
    logic [PRIORITY_BITS-1:0] priority_req = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [1:0]               status;
    logic [ID_BITS-1:0]       served_id;
    logic [CNT_W-1:0]         occupancy;

    int              send_idle_pct = 14;
    int              recv_idle_pct = 64;
    int              quiet_cycles = 0;
    queue_scoreboard sb = new();

    stable_priority_queue DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .requester_id (requester_id),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .served_id    (served_id),
        .occupancy    (occupancy)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_response(status, served_id, occupancy);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(logic [1:0] op, logic [ID_BITS-1:0] id,
                                logic [PRIORITY_BITS-1:0] pri);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        requester_id <= id;
        priority_req <= pri;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sb.predict_request(op, id, pri);
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_responses.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic run_random(int count);
        logic [1:0]               op;
        logic [ID_BITS-1:0]       id;
        logic [PRIORITY_BITS-1:0] pri;
        bit                       filling;
        int                       roll;
        int                       n;
        filling = 1'b1;
        for (n = 0; n < count; n++)
        begin
            if (sb.entry_count == QUEUE_DEPTH && $urandom_range(0, 3) == 0)
            begin
                filling = 1'b0;
            end
            else if (sb.entry_count == 0 && $urandom_range(0, 3) == 0)
            begin
                filling = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (filling)
            begin
                op = (roll < 50) ? OP_INSERT : (roll < 70) ? OP_UPDATE :
                     (roll < 82) ? OP_REMOVE : OP_SERVE;
            end
            else
            begin
                op = (roll < 45) ? OP_SERVE : (roll < 70) ? OP_REMOVE :
                     (roll < 85) ? OP_INSERT : OP_UPDATE;
            end
            roll = $urandom_range(0, 3);
            if (roll == 0)
            begin
                id = ID_BITS'($urandom_range(0, 255));
            end
            else if (roll == 1 || sb.entry_count == 0)
            begin
                id = ID_BITS'($urandom_range(0, 15));
            end
            else
            begin
                id = sb.entry_ids[$urandom_range(0, sb.entry_count - 1)];
            end
            pri = $urandom_range(0, 1) ? PRIORITY_BITS'($urandom_range(0, 7))
                                       : PRIORITY_BITS'($urandom_range(0, 255));
            send_request(op, id, pri);
        end
        wait_for_drain();
    endtask

    initial
    begin
        int k;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_request(OP_SERVE, 8'd0, 8'd0);
        send_request(OP_REMOVE, 8'd255, 8'd0);
        send_request(OP_UPDATE, 8'd3, 8'd9);
        send_request(OP_INSERT, 8'd0, 8'd255);
        send_request(OP_INSERT, 8'd255, 8'd0);
        send_request(OP_INSERT, 8'd7, 8'd0);
        send_request(OP_INSERT, 8'd7, 8'd128);
        send_request(OP_UPDATE, 8'd7, 8'd255);
        send_request(OP_REMOVE, 8'd99, 8'd0);
        send_request(OP_REMOVE, 8'd7, 8'd0);
        for (k = 0; k < 12; k++)
        begin
            send_request(OP_INSERT, 8'(40 + k), 8'(k % 3));
        end
        send_request(OP_INSERT, 8'd170, 8'd85);
        send_request(OP_UPDATE, 8'd201, 8'd1);
        send_request(OP_UPDATE, 8'd0, 8'd1);
        wait_for_drain();

        run_random(PHASE_ITEMS);
        send_idle_pct = 64;
        recv_idle_pct = 14;
        run_random(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_ITEMS);

        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_responses.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
